// ===== design/spd_pkg.sv =====
// Package for the slotted page directory: field widths, page geometry,
// opcode and status codes, and the stage-one record type. No dependencies.
`default_nettype none

package spd_pkg;

  // Page geometry
  localparam int PAGE_BYTES    = 4096;
  localparam int HEADER_BYTES  = 32;
  localparam int SLOT_BYTES    = 8;
  localparam int RESERVE_SLOTS = 16;
  localparam int MAX_SLOTS_DEF = 512;

  // Field widths
  localparam int OPC_W  = 2;
  localparam int SIZE_W = 12;
  localparam int IDX_W  = 9;
  localparam int CAP_W  = 12;
  localparam int ST_W   = 2;
  localparam int SLOT_W = 9;
  localparam int OFF_W  = 13;
  localparam int LEN_W  = 12;
  localparam int FREE_W = 13;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;
  localparam int ENTRY_W     = OFF_W + LEN_W;

  // Free space right after a clear: page less header and slot reserve
  localparam int USED_INIT = HEADER_BYTES + RESERVE_SLOTS * SLOT_BYTES;
  localparam int FREE_INIT = (PAGE_BYTES > USED_INIT) ? PAGE_BYTES - USED_INIT : 0;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_GET    = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_SMALL     = 2'd3
  } status_t;

  // Decoded request held between the directory stage and the response stage
  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [OFF_W-1:0]   offset;
    logic [LEN_W-1:0]   length;
    logic [FREE_W-1:0]  free;
    logic               from_ram;
    logic [CAP_W-1:0]   cap;
  } s1_t;

endpackage

`default_nettype wire

// ===== design/spd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/spd_dir.sv =====
// Directory stage: page counters, insert/get/clear decode and the slot RAM.
// Depends on spd_pkg and spd_ram.
`default_nettype none

module spd_dir #(
  parameter int MAX_SLOTS = spd_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_accept,
  input  wire logic                        s1_take,
  input  wire logic [spd_pkg::OPC_W-1:0]   in_opcode,
  input  wire logic [spd_pkg::SIZE_W-1:0]  in_record_size,
  input  wire logic [spd_pkg::IDX_W-1:0]   in_slot_index,
  input  wire logic [spd_pkg::CAP_W-1:0]   in_buffer_capacity,
  output logic                             s1_valid_r,
  output spd_pkg::s1_t                     s1_r,
  output logic [spd_pkg::ENTRY_W-1:0]      ram_rdata
);

  import spd_pkg::*;

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);

  logic [CW-1:0]     count_r, count_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [OFF_W-1:0]  low_r, low_nxt;
  logic              s1_valid_nxt;
  s1_t               s1_nxt;

  logic [FREE_W:0]   needed;
  logic              full;
  logic              hit;
  logic [OFF_W-1:0]  place;
  logic              ram_we, ram_re;

  // insert sizing: record plus one slot entry
  assign needed = (FREE_W+1)'(in_record_size) + (FREE_W+1)'(SLOT_BYTES);
  assign full   = ({1'b0, free_r} < needed) || (count_r >= CW'(MAX_SLOTS)) ||
                  (low_r < OFF_W'(in_record_size));
  assign place  = low_r - OFF_W'(in_record_size);
  assign hit    = 32'(in_slot_index) < 32'(count_r);

  // request decode and counter update
  always_comb begin
    count_nxt = count_r;
    free_nxt  = free_r;
    low_nxt   = low_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    s1_nxt    = '0;
    s1_nxt.status = ST_NOT_FOUND;
    s1_nxt.free   = free_r;
    s1_nxt.cap    = in_buffer_capacity;
    if (in_accept) begin
      case (op_t'(in_opcode))
        OP_INSERT: begin
          if (full) begin
            s1_nxt.status = ST_FULL;
          end else begin
            ram_we        = 1'b1;
            count_nxt     = count_r + CW'(1);
            free_nxt      = FREE_W'({1'b0, free_r} - needed);
            low_nxt       = place;
            s1_nxt.status = ST_OK;
            s1_nxt.slot   = SLOT_W'(count_r);
            s1_nxt.offset = place;
            s1_nxt.length = in_record_size;
            s1_nxt.free   = FREE_W'({1'b0, free_r} - needed);
          end
        end
        OP_GET: begin
          s1_nxt.slot = SLOT_W'(in_slot_index);
          if (hit) begin
            ram_re          = 1'b1;
            s1_nxt.status   = ST_OK;
            s1_nxt.from_ram = 1'b1;
          end
        end
        OP_CLEAR: begin
          count_nxt     = '0;
          free_nxt      = FREE_W'(FREE_INIT);
          low_nxt       = OFF_W'(PAGE_BYTES);
          s1_nxt.status = ST_OK;
          s1_nxt.offset = OFF_W'(PAGE_BYTES);
          s1_nxt.free   = FREE_W'(FREE_INIT);
        end
        default: begin
          s1_nxt.status = ST_NOT_FOUND;
        end
      endcase
    end
  end

  // stage-one occupancy
  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      free_r     <= FREE_W'(FREE_INIT);
      low_r      <= OFF_W'(PAGE_BYTES);
      s1_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      free_r     <= free_nxt;
      low_r      <= low_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload, loaded only with a new transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
  end

  // slot table: {offset, length} per slot
  spd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (AW'(count_r)),
    .wdata   ({place, in_record_size}),
    .re      (ram_re),
    .raddr   (AW'(in_slot_index)),
    .rdata_r (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== design/spd_resp.sv =====
// Response stage: merges slot RAM data for gets, checks buffer size,
// and holds the result in the output register. Depends on spd_pkg.
`default_nettype none

module spd_resp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           s1_valid,
  input  wire spd_pkg::s1_t                   s1,
  input  wire logic [spd_pkg::ENTRY_W-1:0]    ram_rdata,
  input  wire logic                           out_tready,
  output logic                                out_tvalid,
  output logic [spd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                take
);

  import spd_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - (ST_W + SLOT_W + OFF_W + LEN_W + FREE_W);

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  status_t                st;
  logic [OFF_W-1:0]       off;
  logic [LEN_W-1:0]       len;

  // output register free or draining this cycle
  assign take = !out_valid_r || out_tready;

  // final fields: gets that hit take offset and length from the slot RAM
  always_comb begin
    st  = s1.status;
    off = s1.offset;
    len = s1.length;
    if (s1.from_ram) begin
      off = ram_rdata[ENTRY_W-1:LEN_W];
      len = ram_rdata[LEN_W-1:0];
      st  = (s1.cap < ram_rdata[LEN_W-1:0]) ? ST_SMALL : ST_OK;
    end
    out_data_nxt = {PAD_W'(0), s1.free, len, off, s1.slot, st};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== design/slotted_page_directory_unit.sv =====
// Slotted page directory, top level. Each transaction passes the stage-one
// register, then the output register. Throughput: one transaction per cycle
// unless the output stalls; a fitting insert writes the slot RAM and counters,
// a hitting get does a registered slot RAM read, a clear resets the counters.
// Reset clears the counters and handshake state; the slot RAM is not cleared,
// since only slots below the record count are ever read. Depends on spd_pkg.
`default_nettype none

module slotted_page_directory_unit #(
  parameter int MAX_SLOTS = spd_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // opcode[1:0], record_size[13:2], slot_index[22:14], buffer_capacity[34:23]
  input  wire logic [spd_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // status[1:0], slot_number[10:2], rec_offset[23:11], record_length[35:24],
  // free_bytes[48:36]
  output logic [spd_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  import spd_pkg::*;

  logic                 in_accept;
  logic                 take;
  logic                 s1_valid;
  s1_t                  s1;
  logic [ENTRY_W-1:0]   ram_rdata;

  assign in_tready = !s1_valid || take;
  assign in_accept = in_tvalid && in_tready;

  spd_dir #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dir (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_accept          (in_accept),
    .s1_take            (take),
    .in_opcode          (in_tdata[1:0]),
    .in_record_size     (in_tdata[13:2]),
    .in_slot_index      (in_tdata[22:14]),
    .in_buffer_capacity (in_tdata[34:23]),
    .s1_valid_r         (s1_valid),
    .s1_r               (s1),
    .ram_rdata          (ram_rdata)
  );

  spd_resp u_resp (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .ram_rdata  (ram_rdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .take       (take)
  );

endmodule

`default_nettype wire

// ===== design/spd_checker.sv =====
// Port-level checks for the slotted page directory, bound to the top level.
// Depends on spd_pkg.
`default_nettype none

module spd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [spd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import spd_pkg::*;

  // a stalled result holds its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // a too-small buffer always reports a nonzero stored length
  a_small_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_SMALL) |-> (out_tdata[35:24] != '0))
    else $error("buffer too small with zero length");

  // a full page reports no slot, offset or length
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_FULL) |-> (out_tdata[35:2] == '0))
    else $error("page full with nonzero fields");

endmodule

bind slotted_page_directory_unit spd_checker u_spd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
